// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SKSH_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define SKSH_NEVER(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition");
`else
`define SKSH_ASSERT(lbl, prop)
`define SKSH_NEVER(lbl, expr)
`endif
`endif

// File: hw/rtl/sksh_pkg.sv
// Shared constants, codes and the arctangent table of the station keeping unit.
package sksh_pkg;

    localparam int COORD_BITS = 24;
    localparam int STN_BITS  = 24;
    localparam int RAD_BITS  = 20;
    localparam int SPD_BITS  = 12;
    localparam int DIST_BITS = 25;
    localparam int HEAD_BITS = 16;
    localparam int ITER_BITS = 5;
    localparam int ATAN_BITS = 21;
    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [DIST_BITS-1:0] DIST_MAX = 25'd33554431;

    // depth hysteresis
    localparam logic [1:0] DEPTH_DISABLED = 2'd0;
    localparam logic [1:0] DEPTH_INACTIVE = 2'd1;
    localparam logic [1:0] DEPTH_ACTIVE   = 2'd2;

    // result status
    localparam logic [2:0] ST_ACTION   = 3'd0;
    localparam logic [2:0] ST_NO_POS   = 3'd1;
    localparam logic [2:0] ST_UNSET    = 3'd2;
    localparam logic [2:0] ST_DEPTH    = 3'd3;
    localparam logic [2:0] ST_INSIDE   = 3'd4;
    localparam logic [2:0] ST_IDLE     = 3'd5;

    // register map
    localparam logic [2:0] REG_STATION_X = 3'd0;
    localparam logic [2:0] REG_STATION_Y = 3'd1;
    localparam logic [2:0] REG_MODE      = 3'd2;
    localparam logic [2:0] REG_INNER     = 3'd3;
    localparam logic [2:0] REG_OUTER     = 3'd4;
    localparam logic [2:0] REG_OUTER_SPD = 3'd5;
    localparam logic [2:0] REG_EXTRA_SPD = 3'd6;
    localparam logic [2:0] REG_DEPTH_RAD = 3'd7;

    // input command
    localparam logic CMD_RUN  = 1'b0;
    localparam logic CMD_IDLE = 1'b1;

    // atan(2^-i) in 1/256 of 0.01 degree
    function automatic logic [ATAN_BITS-1:0] atan_lut(input logic [ITER_BITS-1:0] i);
        logic [ATAN_BITS-1:0] r;
        unique case (i)
            5'd0:  r = 21'd1152000;
            5'd1:  r = 21'd680065;
            5'd2:  r = 21'd359328;
            5'd3:  r = 21'd182400;
            5'd4:  r = 21'd91554;
            5'd5:  r = 21'd45822;
            5'd6:  r = 21'd22916;
            5'd7:  r = 21'd11459;
            5'd8:  r = 21'd5730;
            5'd9:  r = 21'd2865;
            5'd10: r = 21'd1432;
            5'd11: r = 21'd716;
            5'd12: r = 21'd358;
            5'd13: r = 21'd179;
            5'd14: r = 21'd90;
            5'd15: r = 21'd45;
            5'd16: r = 21'd22;
            5'd17: r = 21'd11;
            5'd18: r = 21'd6;
            5'd19: r = 21'd3;
            5'd20: r = 21'd1;
            5'd21: r = 21'd1;
            default: r = 21'd0;
        endcase
        return r;
    endfunction

endpackage

// File: hw/rtl/sksh_ifs.sv
// Channel interfaces: position input, result output, register writes.
interface sksh_in_if ();
    logic                                       valid;
    logic                                       ready;
    logic                                       cmd;
    logic                                       nav_valid;
    logic signed [sksh_pkg::COORD_BITS-1:0]     own_x;
    logic signed [sksh_pkg::COORD_BITS-1:0]     own_y;
    modport source (output valid, cmd, nav_valid, own_x, own_y, input ready);
    modport sink   (input valid, cmd, nav_valid, own_x, own_y, output ready);
endinterface

interface sksh_out_if ();
    logic                                valid;
    logic                                ready;
    logic [2:0]                          status;
    logic [sksh_pkg::DIST_BITS-1:0]      distance;
    logic [sksh_pkg::HEAD_BITS-1:0]      heading;
    logic [sksh_pkg::SPD_BITS-1:0]       speed;
    logic [1:0]                          depth_state;
    logic                                station_known;
    modport source (output valid, status, distance, heading, speed, depth_state,
                    station_known, input ready);
    modport sink   (input valid, status, distance, heading, speed, depth_state,
                    station_known, output ready);
endinterface

interface sksh_cfg_if ();
    logic                               valid;
    logic                               ready;
    logic [sksh_pkg::CFG_ADDR_BITS-1:0] addr;
    logic [sksh_pkg::CFG_DATA_BITS-1:0] data;
    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

// File: hw/rtl/station_keep_speed_heading_unit.sv
// Station keeping unit: distance, bearing and desired speed toward a station point.
//
//  channel | dir | transfer                  | payload
//  --------+-----+---------------------------+--------------------------------------
//  din     | in  | one position/idle item    | cmd, nav_valid, own_x, own_y
//  dout    | out | one result per item       | status, distance, heading, speed,
//          |     |                           | depth_state, station_known
//  cfg     | in  | one register write        | addr (register index), data
//
// Idle, no-position and unset items go from the idle state straight to the done state,
// which loads the output register. A run item passes through distance (two squarings,
// sum, 26 radix-4 root steps unless the difference saturates, evaluate); when action is
// requested, it runs the ramp divider (multiply, setup, 12 quotient bits) if below the
// outer radius, then the bearing CORDIC. One item is in work at a time;
// din.ready is high only while the engine is free. A finished result sits in the output
// register, so the next item is taken while dout stalls; a second result waits in the
// done state until dout drains.
// Reset (async, rst_n low) loads register defaults and clears all station state.
// cfg.ready is high only while the engine is idle and no item is offered.
`include "assert_macros.svh"

module station_keep_speed_heading_unit #(
    parameter int ANGLE_ITERATIONS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    sksh_in_if.sink    din,
    sksh_out_if.source dout,
    sksh_cfg_if.sink   cfg
);

    localparam int COORD_BITS = sksh_pkg::COORD_BITS;
    localparam int DW = COORD_BITS + 1;   // coordinate difference
    localparam int CW = COORD_BITS + 19;  // CORDIC vector: x65536, gain and sign

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SQ_X   = 4'd1;
    localparam logic [3:0] S_SQ_Y   = 4'd2;
    localparam logic [3:0] S_SUM    = 4'd3;
    localparam logic [3:0] S_SQRT   = 4'd4;
    localparam logic [3:0] S_EVAL   = 4'd5;
    localparam logic [3:0] S_MUL    = 4'd6;
    localparam logic [3:0] S_DIVI   = 4'd7;
    localparam logic [3:0] S_DIV    = 4'd8;
    localparam logic [3:0] S_CINIT  = 4'd9;
    localparam logic [3:0] S_CORDIC = 4'd10;
    localparam logic [3:0] S_HFIN   = 4'd11;
    localparam logic [3:0] S_DONE   = 4'd12;

    localparam logic [sksh_pkg::ITER_BITS-1:0] ITER_LAST =
        sksh_pkg::ITER_BITS'(ANGLE_ITERATIONS - 1);

    function automatic logic signed [COORD_BITS-1:0] stn_ext(
        input logic [sksh_pkg::STN_BITS-1:0] v);
        return $signed(COORD_BITS'(v));
    endfunction

    // ---------------- registers ----------------
    logic [3:0] state_reg;

    // configuration
    logic [sksh_pkg::STN_BITS-1:0] stx_reg, sty_reg;
    logic [1:0]                    mode_reg;
    logic [sksh_pkg::RAD_BITS-1:0] inner_reg, outer_reg, drad_reg;
    logic [sksh_pkg::SPD_BITS-1:0] ospd_reg, xspd_reg;

    // station state
    logic signed [COORD_BITS-1:0] sst_x_reg, sst_y_reg;
    logic                         set_reg, pend_reg;
    logic [1:0]                   depth_reg;

    // datapath
    logic signed [DW-1:0]          dx_reg, dy_reg;
    logic                          sat_reg, zero_reg;
    logic [49:0]                   sqx_reg, sqy_reg;
    logic [51:0]                   rad_reg;    // operand shifted out two bits a cycle
    logic [27:0]                   rem_reg;
    logic [25:0]                   root_reg;
    logic [4:0]                    cnt_reg;
    logic [31:0]                   prod_reg;
    logic [20:0]                   dvs_reg, drem_reg;
    logic [11:0]                   dq_reg;     // dividend low bits in, quotient out
    logic signed [CW-1:0]          ca_reg, cb_reg;
    logic signed [24:0]            acc_reg;
    logic [sksh_pkg::ITER_BITS-1:0] iter_reg;

    // result being built
    logic [2:0]                     rst_reg;
    logic [sksh_pkg::DIST_BITS-1:0] dist_reg;
    logic [sksh_pkg::HEAD_BITS-1:0] head_reg;
    logic [sksh_pkg::SPD_BITS-1:0]  spd_reg;

    // output register
    logic                           ov_reg;
    logic [2:0]                     o_status_reg;
    logic [sksh_pkg::DIST_BITS-1:0] o_dist_reg;
    logic [sksh_pkg::HEAD_BITS-1:0] o_head_reg;
    logic [sksh_pkg::SPD_BITS-1:0]  o_spd_reg;
    logic [1:0]                     o_depth_reg;
    logic                           o_known_reg;

    // ---------------- config write decode ----------------
    logic                          cfg_wr;
    logic [sksh_pkg::STN_BITS-1:0] new_stx, new_sty;
    logic [1:0]                    new_mode;
    logic                          stn_load;

    // writes only land while the engine is free and no item is offered
    assign cfg.ready = (state_reg == S_IDLE) && !din.valid;
    assign cfg_wr    = cfg.valid && cfg.ready;
    assign new_stx   = (cfg_wr && cfg.addr == sksh_pkg::REG_STATION_X) ?
                       cfg.data[sksh_pkg::STN_BITS-1:0] : stx_reg;
    assign new_sty   = (cfg_wr && cfg.addr == sksh_pkg::REG_STATION_Y) ?
                       cfg.data[sksh_pkg::STN_BITS-1:0] : sty_reg;
    assign new_mode  = (cfg_wr && cfg.addr == sksh_pkg::REG_MODE) ?
                       cfg.data[1:0] : mode_reg;
    // any station or mode write reloads the station when bit0 is set
    assign stn_load  = cfg_wr && new_mode[0] && (cfg.addr == sksh_pkg::REG_STATION_X ||
                       cfg.addr == sksh_pkg::REG_STATION_Y || cfg.addr == sksh_pkg::REG_MODE);

    // ---------------- input side ----------------
    logic                         in_acc;
    logic signed [COORD_BITS-1:0] eff_x, eff_y;
    logic                         eff_set;

    assign din.ready = (state_reg == S_IDLE);
    assign in_acc    = din.valid && din.ready;
    // pending capture takes the present position as the station
    assign eff_x     = pend_reg ? din.own_x : sst_x_reg;
    assign eff_y     = pend_reg ? din.own_y : sst_y_reg;
    assign eff_set   = set_reg | pend_reg;

    // ---------------- distance ----------------
    logic signed [33:0] dxe, dye, mxe, mye;
    logic               sat_c;

    assign dxe   = 34'(dx_reg);
    assign dye   = 34'(dy_reg);
    assign mxe   = (dxe < 0) ? -dxe : dxe;
    assign mye   = (dye < 0) ? -dye : dye;
    assign sat_c = (dxe >= 34'sd33554432) || (dxe <= -34'sd33554432) ||
                   (dye >= 34'sd33554432) || (dye <= -34'sd33554432);

    logic [29:0] sq_rem2, sq_trial;
    logic        sq_ge;

    assign sq_rem2  = {rem_reg, rad_reg[51:50]};
    assign sq_trial = 30'({root_reg, 2'b01});
    assign sq_ge    = sq_rem2 >= sq_trial;

    logic [26:0]                    root_rnd;
    logic [sksh_pkg::DIST_BITS-1:0] dist_c;

    // round half up: remainder above root means past the midpoint
    assign root_rnd = (rem_reg > {2'b00, root_reg}) ? 27'(root_reg) + 27'd1 : 27'(root_reg);
    assign dist_c   = (sat_reg || root_rnd > 27'(sksh_pkg::DIST_MAX)) ? sksh_pkg::DIST_MAX :
                      root_rnd[sksh_pkg::DIST_BITS-1:0];

    logic [1:0] depth_c;
    logic       inside_c;

    assign inside_c = dist_c <= sksh_pkg::DIST_BITS'(inner_reg);
    always_comb
    begin
        depth_c = depth_reg;
        if (depth_reg == sksh_pkg::DEPTH_INACTIVE)
        begin
            if (dist_c > sksh_pkg::DIST_BITS'(drad_reg))
                depth_c = sksh_pkg::DEPTH_ACTIVE;
        end
        else if (depth_reg == sksh_pkg::DEPTH_ACTIVE)
        begin
            if (inside_c)
                depth_c = sksh_pkg::DEPTH_INACTIVE;
        end
    end

    // ---------------- ramp divider ----------------
    logic [sksh_pkg::RAD_BITS-1:0] range_c;
    logic [33:0]                   ramp_num;
    logic [21:0]                   dv_rem2;
    logic                          dv_ge;

    assign range_c  = outer_reg - inner_reg;
    assign ramp_num = {1'b0, prod_reg, 1'b0} + 34'(range_c);
    assign dv_rem2  = {drem_reg, dq_reg[11]};
    assign dv_ge    = dv_rem2 >= {1'b0, dvs_reg};

    // ---------------- CORDIC ----------------
    logic signed [CW-1:0] ca0, cb0, sa, sb;
    logic signed [24:0]   atan_s;

    assign ca0    = CW'(dy_reg) <<< 16;
    assign cb0    = CW'(dx_reg) <<< 16;
    assign sa     = ca_reg >>> iter_reg;
    assign sb     = cb_reg >>> iter_reg;
    assign atan_s = $signed({4'b0000, sksh_pkg::atan_lut(iter_reg)});

    logic [25:0] hd_t;
    logic [17:0] hd_q;
    logic [17:0] hd_m;

    assign hd_t = 26'(acc_reg) + 26'd18432128;   // +720 degrees and rounding half
    assign hd_q = hd_t[25:8];
    assign hd_m = (hd_q >= 18'd72000) ? hd_q - 18'd72000 :
                  (hd_q >= 18'd36000) ? hd_q - 18'd36000 : hd_q;

    // ---------------- sequencer ----------------
    logic out_free;
    assign out_free = !ov_reg || dout.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            stx_reg      <= '0;
            sty_reg      <= '0;
            mode_reg     <= '0;
            inner_reg    <= 20'd400;
            outer_reg    <= 20'd1500;
            ospd_reg     <= 12'd120;
            xspd_reg     <= 12'd250;
            drad_reg     <= '0;
            sst_x_reg    <= '0;
            sst_y_reg    <= '0;
            set_reg      <= 1'b0;
            pend_reg     <= 1'b0;
            depth_reg    <= sksh_pkg::DEPTH_DISABLED;
            dx_reg       <= '0;
            dy_reg       <= '0;
            sat_reg      <= 1'b0;
            zero_reg     <= 1'b0;
            sqx_reg      <= '0;
            sqy_reg      <= '0;
            rad_reg      <= '0;
            rem_reg      <= '0;
            root_reg     <= '0;
            cnt_reg      <= '0;
            prod_reg     <= '0;
            dvs_reg      <= '0;
            drem_reg     <= '0;
            dq_reg       <= '0;
            ca_reg       <= '0;
            cb_reg       <= '0;
            acc_reg      <= '0;
            iter_reg     <= '0;
            rst_reg      <= sksh_pkg::ST_IDLE;
            dist_reg     <= '0;
            head_reg     <= '0;
            spd_reg      <= '0;
            ov_reg       <= 1'b0;
            o_status_reg <= '0;
            o_dist_reg   <= '0;
            o_head_reg   <= '0;
            o_spd_reg    <= '0;
            o_depth_reg  <= '0;
            o_known_reg  <= 1'b0;
        end
        else
        begin
            // the done state reloads the output register itself
            if (ov_reg && dout.ready && state_reg != S_DONE)
                ov_reg <= 1'b0;

            // register writes
            if (cfg_wr)
            begin
                unique case (cfg.addr)
                    sksh_pkg::REG_STATION_X: stx_reg  <= new_stx;
                    sksh_pkg::REG_STATION_Y: sty_reg  <= new_sty;
                    sksh_pkg::REG_MODE:      mode_reg <= new_mode;
                    sksh_pkg::REG_INNER:
                        if (cfg.data[19:0] != '0)
                            inner_reg <= cfg.data[19:0];
                    sksh_pkg::REG_OUTER:
                        if (cfg.data[19:0] != '0)
                            outer_reg <= cfg.data[19:0];
                    sksh_pkg::REG_OUTER_SPD:
                        if (cfg.data[11:0] != '0)
                        begin
                            ospd_reg <= cfg.data[11:0];
                            if (xspd_reg < cfg.data[11:0])
                                xspd_reg <= cfg.data[11:0];
                        end
                    sksh_pkg::REG_EXTRA_SPD:
                        if (cfg.data[11:0] != '0)
                            xspd_reg <= cfg.data[11:0];
                    sksh_pkg::REG_DEPTH_RAD:
                    begin
                        drad_reg <= cfg.data[19:0];
                        if (cfg.data[19:0] == '0)
                            depth_reg <= sksh_pkg::DEPTH_DISABLED;
                        else if (depth_reg == sksh_pkg::DEPTH_DISABLED)
                            depth_reg <= sksh_pkg::DEPTH_INACTIVE;
                    end
                    default: ;
                endcase
                if (stn_load)
                begin
                    sst_x_reg <= stn_ext(new_stx);
                    sst_y_reg <= stn_ext(new_sty);
                    set_reg   <= 1'b1;
                    pend_reg  <= 1'b0;
                end
            end

            unique case (state_reg)
                S_IDLE:
                    if (in_acc)
                    begin
                        dist_reg <= '0;
                        head_reg <= '0;
                        spd_reg  <= '0;
                        state_reg <= S_DONE;
                        if (din.cmd == sksh_pkg::CMD_IDLE)
                        begin
                            if (mode_reg[1])
                                pend_reg <= 1'b1;
                            rst_reg <= sksh_pkg::ST_IDLE;
                        end
                        else if (!din.nav_valid)
                            rst_reg <= sksh_pkg::ST_NO_POS;
                        else
                        begin
                            if (pend_reg)
                            begin
                                sst_x_reg <= din.own_x;
                                sst_y_reg <= din.own_y;
                                set_reg   <= 1'b1;
                                pend_reg  <= 1'b0;
                            end
                            if (!eff_set)
                                rst_reg <= sksh_pkg::ST_UNSET;
                            else
                            begin
                                dx_reg    <= DW'(eff_x) - DW'(din.own_x);
                                dy_reg    <= DW'(eff_y) - DW'(din.own_y);
                                state_reg <= S_SQ_X;
                            end
                        end
                    end
                S_SQ_X:
                begin
                    sat_reg   <= sat_c;
                    zero_reg  <= (dx_reg == '0) && (dy_reg == '0);
                    sqx_reg   <= mxe[24:0] * mxe[24:0];
                    state_reg <= S_SQ_Y;
                end
                S_SQ_Y:
                begin
                    sqy_reg   <= mye[24:0] * mye[24:0];
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    rad_reg   <= 52'(sqx_reg) + 52'(sqy_reg);
                    rem_reg   <= '0;
                    root_reg  <= '0;
                    cnt_reg   <= 5'd25;
                    state_reg <= sat_reg ? S_EVAL : S_SQRT;
                end
                S_SQRT:
                begin
                    rem_reg  <= sq_ge ? 28'(sq_rem2 - sq_trial) : sq_rem2[27:0];
                    root_reg <= {root_reg[24:0], sq_ge};
                    rad_reg  <= {rad_reg[49:0], 2'b00};
                    cnt_reg  <= cnt_reg - 5'd1;
                    if (cnt_reg == '0)
                        state_reg <= S_EVAL;
                end
                S_EVAL:
                begin
                    dist_reg  <= dist_c;
                    depth_reg <= depth_c;
                    state_reg <= S_DONE;
                    if (depth_c == sksh_pkg::DEPTH_INACTIVE)
                        rst_reg <= sksh_pkg::ST_DEPTH;
                    else if (inside_c)
                        rst_reg <= sksh_pkg::ST_INSIDE;
                    else
                    begin
                        rst_reg <= sksh_pkg::ST_ACTION;
                        if (dist_c < sksh_pkg::DIST_BITS'(outer_reg))
                            state_reg <= S_MUL;
                        else
                        begin
                            spd_reg   <= xspd_reg;
                            state_reg <= S_CINIT;
                        end
                    end
                end
                S_MUL:
                begin
                    // below outer radius, so the excess fits the radius width
                    prod_reg  <= 32'(sksh_pkg::RAD_BITS'(dist_reg -
                                 sksh_pkg::DIST_BITS'(inner_reg)) * ospd_reg);
                    state_reg <= S_DIVI;
                end
                S_DIVI:
                begin
                    drem_reg  <= ramp_num[32:12];
                    dq_reg    <= ramp_num[11:0];
                    dvs_reg   <= {range_c, 1'b0};
                    cnt_reg   <= 5'd11;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    drem_reg <= dv_ge ? 21'(dv_rem2 - {1'b0, dvs_reg}) : dv_rem2[20:0];
                    dq_reg   <= {dq_reg[10:0], dv_ge};
                    cnt_reg  <= cnt_reg - 5'd1;
                    if (cnt_reg == '0)
                    begin
                        spd_reg   <= {dq_reg[10:0], dv_ge};
                        state_reg <= S_CINIT;
                    end
                end
                S_CINIT:
                begin
                    iter_reg <= '0;
                    if (ca0 < 0)
                    begin
                        ca_reg  <= -ca0;
                        cb_reg  <= -cb0;
                        acc_reg <= 25'sd4608000;
                    end
                    else
                    begin
                        ca_reg  <= ca0;
                        cb_reg  <= cb0;
                        acc_reg <= '0;
                    end
                    state_reg <= S_CORDIC;
                end
                S_CORDIC:
                begin
                    if (cb_reg > 0)
                    begin
                        ca_reg  <= ca_reg + sb;
                        cb_reg  <= cb_reg - sa;
                        acc_reg <= acc_reg + atan_s;
                    end
                    else
                    begin
                        ca_reg  <= ca_reg - sb;
                        cb_reg  <= cb_reg + sa;
                        acc_reg <= acc_reg - atan_s;
                    end
                    iter_reg <= iter_reg + 1'b1;
                    if (iter_reg == ITER_LAST)
                        state_reg <= S_HFIN;
                end
                S_HFIN:
                begin
                    head_reg  <= zero_reg ? '0 : hd_m[sksh_pkg::HEAD_BITS-1:0];
                    state_reg <= S_DONE;
                end
                S_DONE:
                    if (out_free)
                    begin
                        ov_reg       <= 1'b1;
                        o_status_reg <= rst_reg;
                        o_dist_reg   <= dist_reg;
                        o_head_reg   <= head_reg;
                        o_spd_reg    <= spd_reg;
                        o_depth_reg  <= depth_reg;
                        o_known_reg  <= set_reg;
                        state_reg    <= S_IDLE;
                    end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign dout.valid         = ov_reg;
    assign dout.status        = o_status_reg;
    assign dout.distance      = o_dist_reg;
    assign dout.heading       = o_head_reg;
    assign dout.speed         = o_spd_reg;
    assign dout.depth_state   = o_depth_reg;
    assign dout.station_known = o_known_reg;

    // ---------------- checks ----------------
    `SKSH_ASSERT(a_busy_after_take, in_acc |=> state_reg != S_IDLE)
    `SKSH_NEVER(a_action_while_inactive, ov_reg && o_status_reg == sksh_pkg::ST_ACTION &&
                o_depth_reg == sksh_pkg::DEPTH_INACTIVE)
    `SKSH_NEVER(a_distance_without_station, ov_reg && !o_known_reg &&
                (o_status_reg == sksh_pkg::ST_ACTION || o_status_reg == sksh_pkg::ST_DEPTH ||
                 o_status_reg == sksh_pkg::ST_INSIDE))
    `SKSH_NEVER(a_heading_range, ov_reg && o_head_reg >= 16'd36000)

endmodule
